// File: hw/rtl/assert_macros.svh
// Assertion macros for the resampler top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assert");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assert");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: hw/rtl/spcr_pkg.sv
// ----------------------------------------------------------------------------
// Cubic resampler package
// Shared payload types, opcodes and register indexes.
// ----------------------------------------------------------------------------
package spcr_pkg;
  localparam int PosBits = 40;
  localparam int FracBits = 16;
  localparam int SampleBits = 16;
  localparam int AddrBits = 16;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SEEK   = 2'd1,
    OP_RENDER = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_STEP   = 3'd0,
    REG_WSTART = 3'd1,
    REG_WEND   = 3'd2,
    REG_FRAMES = 3'd3,
    REG_STEREO = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        frame_address;
    logic signed [15:0] left_word;
    logic signed [15:0] right_word;
    logic signed [39:0] seek_position;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               active;
  } out_item_t;

  // Classified render job handed from the front to the back.
  typedef enum logic [1:0] {
    MODE_SILENT = 2'd0,
    MODE_RAW    = 2'd1,
    MODE_LINEAR = 2'd2,
    MODE_CUBIC  = 2'd3
  } render_mode_t;

  typedef struct packed {
    render_mode_t      mode;
    logic [AddrBits:0] idx;
    logic [FracBits-1:0] mu;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_H0, BK_H1, BK_H2, BK_OUT
  } back_state_t;
endpackage

// File: hw/rtl/spcr_front.sv
// ----------------------------------------------------------------------------
// Resampler front end
// Accepts commands, keeps the play position and classifies render jobs.
// ----------------------------------------------------------------------------
module spcr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  spcr_pkg::in_item_t   item,
  input  logic [31:0]          position_step,
  input  logic signed [39:0]   window_start,
  input  logic signed [39:0]   window_end,
  input  logic [16:0]          sample_frames,
  input  logic                 stereo_mode,
  output logic                 job_valid,
  output spcr_pkg::job_t       job
);
  import spcr_pkg::*;

  logic signed [PosBits-1:0] play_position;
  logic [AddrBits:0] n;
  logic [AddrBits:0] idx;
  logic in_window;
  render_mode_t mode;

  assign n = sample_frames;
  assign idx = {1'b0, play_position[FracBits +: AddrBits]};
  // Positions above the address range are beyond the sample anyway.
  assign in_window = (play_position >= window_start) && (play_position < window_end)
                     && !play_position[PosBits-1]
                     && (play_position[PosBits-2:FracBits+AddrBits] == '0);

  always_comb begin
    mode = MODE_SILENT;
    if (in_window && idx < n) begin
      if (idx + 17'd1 < n) begin
        mode = (idx != '0 && idx + 17'd2 < n) ? MODE_CUBIC : MODE_LINEAR;
      end else if (!stereo_mode) begin
        mode = MODE_RAW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_position <= '0;
      job_valid <= 1'b0;
    end else begin
      job_valid <= 1'b0;
      if (take && item.opcode == OP_SEEK) begin
        play_position <= item.seek_position;
      end else if (take && item.opcode == OP_RENDER) begin
        play_position <= play_position + $signed({8'd0, position_step});
        job_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    job.mode <= mode;
    job.idx <= idx;
    job.mu <= play_position[FracBits-1:0];
  end
endmodule

// File: hw/rtl/spcr_back.sv
// ----------------------------------------------------------------------------
// Resampler back end
// Holds sample memory, reads four frames and evaluates the polynomial.
// ----------------------------------------------------------------------------
module spcr_back #(
  parameter int FRAME_DEPTH = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [15:0]          wr_addr,
  input  logic [31:0]          wr_data,
  input  logic                 job_valid,
  input  spcr_pkg::job_t       job,
  input  logic                 stereo_mode,
  output logic                 busy,
  output logic                 result_valid,
  output spcr_pkg::out_item_t  result
);
  import spcr_pkg::*;
  localparam int Aw = $clog2(FRAME_DEPTH);

  logic [31:0] mem [FRAME_DEPTH];
  logic [31:0] rd_data;
  logic [Aw-1:0] rd_addr;
  back_state_t state, state_next;
  job_t cur;
  logic [2:0] rd_cnt;
  logic rd_live;
  logic [1:0] cap_slot;
  logic signed [17:0] yl [4];
  logic signed [17:0] yr [4];
  logic signed [21:0] acc_l, acc_r;
  logic signed [21:0] coef_l, coef_r;
  logic signed [39:0] prod_l, prod_r;
  logic signed [21:0] sh_l, sh_r;
  logic signed [21:0] a0l, a0r, a1l, a1r, a2l, a2r;
  logic signed [39:0] lprod_l, lprod_r;
  logic signed [21:0] lin_l, lin_r;
  logic signed [15:0] sat_l, sat_r;
  logic [16:0] base;
  logic [16:0] addr_full;

  always_ff @(posedge clk) begin
    if (wr_en && {1'b0, wr_addr} < 17'(FRAME_DEPTH)) begin
      mem[wr_addr[Aw-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Cubic reads idx-1..idx+2; linear and raw read idx..idx+3.
  assign base = (cur.mode == MODE_CUBIC) ? cur.idx - 17'd1 : cur.idx;
  assign addr_full = base + {14'd0, rd_cnt};
  assign rd_addr = addr_full[Aw-1:0];

  assign a0l = yl[3] - yl[2] - yl[0] + yl[1];
  assign a0r = yr[3] - yr[2] - yr[0] + yr[1];
  assign a1l = yl[0] - yl[1] - a0l;
  assign a1r = yr[0] - yr[1] - a0r;
  assign a2l = yl[2] - yl[0];
  assign a2r = yr[2] - yr[0];

  assign prod_l = acc_l * $signed({1'b0, cur.mu});
  assign prod_r = acc_r * $signed({1'b0, cur.mu});
  assign sh_l = 22'(prod_l >>> FracBits);
  assign sh_r = 22'(prod_r >>> FracBits);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (job_valid) state_next = BK_READ;
      BK_READ: if (rd_cnt == 3'd5) state_next = BK_H0;
      BK_H0:   state_next = BK_H1;
      BK_H1:   state_next = BK_H2;
      BK_H2:   state_next = BK_OUT;
      BK_OUT:  state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  assign busy = (state != BK_IDLE) || job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      rd_live <= 1'b0;
    end else begin
      state <= state_next;
      rd_live <= (state == BK_READ) && rd_cnt < 3'd4;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE) begin
      cur <= job;
      rd_cnt <= '0;
      cap_slot <= '0;
    end
    if (state == BK_READ) begin
      rd_cnt <= rd_cnt + 3'd1;
      if (rd_live) begin
        yl[cap_slot] <= 18'(signed'(rd_data[31:16]));
        yr[cap_slot] <= 18'(signed'(rd_data[15:0]));
        cap_slot <= cap_slot + 2'd1;
      end
    end
    unique case (state)
      BK_H0: begin
        acc_l <= a0l; acc_r <= a0r; coef_l <= a1l; coef_r <= a1r;
      end
      BK_H1: begin
        acc_l <= sh_l + coef_l; acc_r <= sh_r + coef_r; coef_l <= a2l; coef_r <= a2r;
      end
      BK_H2: begin
        acc_l <= sh_l + coef_l; acc_r <= sh_r + coef_r;
        coef_l <= 22'(yl[1]); coef_r <= 22'(yr[1]);
      end
      default: ;
    endcase
  end

  // Linear: slots 0 and 1 hold idx and idx+1. The product needs 33 bits.
  always_comb begin
    lprod_l = (yl[1] - yl[0]) * $signed({1'b0, cur.mu});
    lprod_r = (yr[1] - yr[0]) * $signed({1'b0, cur.mu});
    lin_l = yl[0] + 22'(lprod_l >>> FracBits);
    lin_r = yr[0] + 22'(lprod_r >>> FracBits);
  end

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) return 16'sd32767;
    if (v < -22'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  always_comb begin
    sat_l = '0;
    sat_r = '0;
    unique case (cur.mode)
      MODE_CUBIC: begin
        sat_l = sat16(sh_l + coef_l);
        sat_r = sat16(sh_r + coef_r);
      end
      MODE_LINEAR: begin
        sat_l = sat16(lin_l);
        sat_r = sat16(lin_r);
      end
      MODE_RAW: begin
        sat_l = yl[0][15:0];
        sat_r = yl[0][15:0];
      end
      default: ;
    endcase
    if (!stereo_mode) sat_r = sat_l;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == BK_OUT);
    end
    if (state == BK_OUT) begin
      result.left_out <= sat_l;
      result.right_out <= sat_r;
      result.active <= (cur.mode != MODE_SILENT);
    end
  end
endmodule

// File: hw/rtl/sample_playback_cubic_resampler_top.sv
// ----------------------------------------------------------------------------
// Cubic sample playback resampler
// Plays stored frames at a fractional rate with cubic interpolation.
// ----------------------------------------------------------------------------
// Usage: drive cmd and pulse start while busy is low. Write and seek
// commands leave busy low and give no result. A render command gives one
// result on result with done high for exactly one cycle; busy stays high
// until that cycle and falls in it, so renders run one at a time. The
// front end registers the job and hands it to the back end, the read state
// fetches four frames through the single registered sample memory read
// port, the states H0, H1 and H2 run the Horner steps, the output state
// finishes and saturates, and the result register holds the output.
// Configuration must be written through cfg_we, cfg_index and cfg_data
// only while no command is in flight; the block does not enforce this.
// Reset clears the position and returns the registers to their defaults;
// sample memory holds garbage until written. Results cannot be stalled,
// so the receiver must take each one in its strobe cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sample_playback_cubic_resampler_top #(
  parameter int FRAME_DEPTH = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  spcr_pkg::in_item_t   cmd,
  output logic                 done,
  output spcr_pkg::out_item_t  result,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [39:0]          cfg_data
);
  import spcr_pkg::*;

  logic [31:0] position_step;
  logic signed [39:0] window_start, window_end;
  logic [16:0] sample_frames, frames_eff;
  logic stereo_mode;
  logic take, job_valid, back_busy, front_busy;
  job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_step <= 32'd1 << FracBits;
      window_start <= '0;
      window_end <= '0;
      sample_frames <= '0;
      stereo_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP:   position_step <= cfg_data[31:0];
        REG_WSTART: window_start <= cfg_data;
        REG_WEND:   window_end <= cfg_data;
        REG_FRAMES: sample_frames <= cfg_data[16:0];
        REG_STEREO: stereo_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign frames_eff = (sample_frames > 17'(FRAME_DEPTH)) ? 17'(FRAME_DEPTH) : sample_frames;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) front_busy <= 1'b0;
    else front_busy <= take && cmd.opcode == OP_RENDER;
  end
  assign busy = front_busy || back_busy;

  spcr_front u_front (
    .clk, .rst, .take, .item(cmd), .position_step, .window_start, .window_end,
    .sample_frames(frames_eff), .stereo_mode, .job_valid, .job
  );

  spcr_back #(.FRAME_DEPTH(FRAME_DEPTH)) u_back (
    .clk, .rst,
    .wr_en(take && cmd.opcode == OP_WRITE),
    .wr_addr(cmd.frame_address),
    .wr_data({cmd.left_word, cmd.right_word}),
    .job_valid, .job, .stereo_mode,
    .busy(back_busy), .result_valid(done), .result
  );

  `ASSERT_NEXT(a_render_busy, clk, rst, take && cmd.opcode == OP_RENDER, busy)
  `ASSERT_IMPLIES(a_done_busy_clear, clk, rst, done, !job_valid)
  `ASSERT_IMPLIES(a_silent_zero, clk, rst, done && !result.active, result.left_out == 16'sd0)
endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Cubic resampler testbench
// Drives write, seek and render commands with random gaps and checks each
// rendered frame against a cycle-free model of position, window and filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;
  import spcr_pkg::*;

  localparam int Depth = 65536;
  localparam int CycleLimit = 400000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_item_t cmd;
  logic done;
  out_item_t result;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [39:0] cfg_data;

  sample_playback_cubic_resampler_top #(.FRAME_DEPTH(Depth)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow state of the player.
  logic signed [15:0] left_mem [Depth];
  logic signed [15:0] right_mem [Depth];
  bit written [Depth];
  logic signed [39:0] play_pos;
  logic [31:0] step_reg;
  logic signed [39:0] win_start;
  logic signed [39:0] win_end;
  logic [16:0] frame_count;
  logic stereo;

  out_item_t frame_queue[$];
  int errors;
  int cycles;

  function automatic longint floor_shr(longint x);
    return x >>> 16;
  endfunction

  function automatic longint filter_at(bit right_ch, int idx, longint n, longint mu);
    longint y0, y1, y2, y3, a0, a1, a2, v;
    y0 = longint'(right_ch ? right_mem[idx] : left_mem[idx]);
    y1 = longint'(right_ch ? right_mem[idx + 1] : left_mem[idx + 1]);
    if (idx > 0 && idx + 2 < n) begin
      y2 = y1;
      y1 = y0;
      y0 = longint'(right_ch ? right_mem[idx - 1] : left_mem[idx - 1]);
      y3 = longint'(right_ch ? right_mem[idx + 2] : left_mem[idx + 2]);
      a0 = y3 - y2 - y0 + y1;
      a1 = y0 - y1 - a0;
      a2 = y2 - y0;
      v = floor_shr(a0 * mu) + a1;
      v = floor_shr(v * mu) + a2;
      return floor_shr(v * mu) + y1;
    end
    return y0 + floor_shr((y1 - y0) * mu);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic out_item_t render_frame();
    out_item_t o;
    longint n, l, r, mu;
    int idx;
    o = '0;
    l = 0;
    r = 0;
    n = (frame_count > 17'(Depth)) ? longint'(Depth) : longint'(frame_count);
    if (play_pos >= win_start && play_pos < win_end && play_pos >= 0) begin
      idx = int'(play_pos >>> 16);
      mu = longint'(play_pos[15:0]);
      if (idx < n) begin
        if (idx + 1 < n) begin
          l = filter_at(1'b0, idx, n, mu);
          r = stereo ? filter_at(1'b1, idx, n, mu) : l;
          o.active = 1'b1;
        end else if (!stereo) begin
          l = longint'(left_mem[idx]);
          r = l;
          o.active = 1'b1;
        end
      end
    end
    o.left_out = clip16(l);
    o.right_out = clip16(r);
    play_pos = play_pos + signed'({8'd0, step_reg});
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
    if (done) begin
      if (frame_queue.size() == 0) begin
        $error("unexpected frame %h", result);
        errors = errors + 1;
      end else begin
        out_item_t e;
        e = frame_queue.pop_front();
        if (result.left_out !== e.left_out) begin
          $error("left_out exp %0d got %0d", e.left_out, result.left_out);
          errors = errors + 1;
        end
        if (result.right_out !== e.right_out) begin
          $error("right_out exp %0d got %0d", e.right_out, result.right_out);
          errors = errors + 1;
        end
        if (result.active !== e.active) begin
          $error("active exp %0d got %0d", e.active, result.active);
          errors = errors + 1;
        end
      end
    end
  end

  // A zero gap keeps start high so the next transaction follows at once.
  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_item(in_item_t it);
    out_item_t exp_frame;
    idle_gap();
    start <= 1'b1;
    cmd <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (opcode_t'(it.opcode))
      OP_WRITE: begin
        left_mem[it.frame_address] = it.left_word;
        right_mem[it.frame_address] = it.right_word;
        written[it.frame_address] = 1'b1;
      end
      OP_SEEK: play_pos = it.seek_position;
      OP_RENDER: begin
        exp_frame = render_frame();
        frame_queue.insert(frame_queue.size(), exp_frame);
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    while (frame_queue.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t ix, logic [39:0] v);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (ix)
      REG_STEP: step_reg = v[31:0];
      REG_WSTART: win_start = v;
      REG_WEND: win_end = v;
      REG_FRAMES: frame_count = v[16:0];
      REG_STEREO: stereo = v[0];
      default: ;
    endcase
  endtask

  task automatic write_frame(int a, logic [15:0] l, logic [15:0] r);
    in_item_t it;
    it = '0;
    it.opcode = OP_WRITE;
    it.frame_address = 16'(a);
    it.left_word = l;
    it.right_word = r;
    send_item(it);
  endtask

  task automatic seek(logic [39:0] p);
    in_item_t it;
    it = '0;
    it.opcode = OP_SEEK;
    it.seek_position = p;
    send_item(it);
  endtask

  task automatic render();
    in_item_t it;
    it = 90'({$urandom, $urandom, $urandom});
    it.opcode = OP_RENDER;
    send_item(it);
  endtask

  // In-window positions need their in-range neighbors idx-1..idx+2 written.
  function automatic bit reads_safe();
    longint idx, n;
    if (!(play_pos >= win_start && play_pos < win_end && play_pos >= 0)) return 1'b1;
    n = (frame_count > 17'(Depth)) ? longint'(Depth) : longint'(frame_count);
    idx = longint'(play_pos >>> 16);
    if (idx >= n) return 1'b1;
    for (longint k = idx - 1; k <= idx + 2; k++)
      if (k >= 0 && k < n && !written[k]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic test_directed();
    write_reg(REG_FRAMES, 40'd8);
    write_reg(REG_WSTART, 40'd0);
    write_reg(REG_WEND, 40'sh7F_FFFF_FFFF);
    write_reg(REG_STEREO, 40'd0);
    write_reg(REG_STEP, 40'h8000);
    write_frame(0, 16'h7FFF, 16'h8000);
    write_frame(1, 16'h8000, 16'h7FFF);
    write_frame(2, 16'h7FFF, 16'h8000);
    write_frame(3, 16'h8000, 16'h7FFF);
    for (int a = 4; a < 8; a++) write_frame(a, 16'($urandom), 16'($urandom));
    seek(40'd0);
    repeat (16) render();
    render();
    begin
      in_item_t it;
      it = 90'({$urandom, $urandom, $urandom});
      it.opcode = OP_NONE;
      send_item(it);
    end
    seek(-40'sd65536);
    render();
    seek(40'sh7F_FFFF_FFFF);
    render();
    render();
    drain();
    write_reg(REG_STEREO, 40'd1);
    seek(40'd0);
    repeat (16) render();
    drain();
  endtask

  task automatic test_random();
    int done_items;
    done_items = 0;
    while (done_items < 1800) begin
      drain();
      write_reg(REG_FRAMES, ($urandom_range(0, 7) == 0) ? 40'h1FFFF :
                40'($urandom_range(0, 40)));
      write_reg(REG_STEREO, 40'($urandom_range(0, 1)));
      write_reg(REG_STEP, ($urandom_range(0, 9) == 0) ? 40'($urandom) :
                40'($urandom_range(0, 200000)));
      write_reg(REG_WSTART, ($urandom_range(0, 5) == 0) ?
                40'({$urandom, $urandom}) : 40'($urandom_range(0, 10) <<< 16));
      write_reg(REG_WEND, ($urandom_range(0, 5) == 0) ?
                40'({$urandom, $urandom}) : 40'($urandom_range(0, 50) <<< 16));
      for (int k = 0; k < 40; k++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            write_frame($urandom_range(0, 45), 16'($urandom), 16'($urandom));
          end
          2: write_frame($urandom, 16'($urandom), 16'($urandom));
          3: seek(($urandom_range(0, 7) == 0) ? 40'({$urandom, $urandom}) :
                  40'({$urandom_range(0, 45), 16'($urandom)}));
          default: begin
            if (reads_safe()) render();
            else write_frame($urandom_range(0, 45), 16'($urandom), 16'($urandom));
          end
        endcase
        done_items++;
      end
      if (done_items % 400 < 40) drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    play_pos = '0;
    step_reg = 32'h10000;
    win_start = '0;
    win_end = '0;
    frame_count = '0;
    stereo = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
